// File: hdl/bit_error_rate_counter_macros.svh
// assertion helpers for the bit error rate counter
`ifndef BIT_ERROR_RATE_COUNTER_MACROS_SVH
`define BIT_ERROR_RATE_COUNTER_MACROS_SVH

// checked on every clock while out of reset
`define BERC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication from one beat to the next cycle, out of reset
`define BERC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/berc_pkg.sv
package berc_pkg;

  localparam int MAX_DELAY_DEF     = 64;
  localparam int MAX_SKIP_LAST_DEF = 64;
  localparam int TOTAL_WIDTH_DEF   = 48;

  localparam int ALIGN_W      = 8;
  localparam int SKIP_FIRST_W = 16;
  localparam int SKIP_LAST_W  = 7;
  localparam int FRAME_W      = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALIGN_DELAY = 2'd0,
    REG_SKIP_FIRST  = 2'd1,
    REG_SKIP_LAST   = 2'd2
  } cfg_reg_t;

endpackage

// File: hdl/bit_error_rate_counter.sv
// an accepted input beat gives a registered result beat on out_valid in the next cycle
// throughput: 1 beat per cycle while out_ready is high; the output register is loaded
// while the previous result is taken, so back-to-back beats flow without bubbles
// reset (rst_n low, synchronous): config, delay line write count and pointer, queue
// head and fill, frame position, totals and frame error count all clear; memory
// contents are masked by those counts, so no clearing pass is needed
`include "bit_error_rate_counter_macros.svh"

module bit_error_rate_counter
  import berc_pkg::*;
#(
  parameter int MAX_DELAY     = MAX_DELAY_DEF,
  parameter int MAX_SKIP_LAST = MAX_SKIP_LAST_DEF,
  parameter int TOTAL_WIDTH   = TOTAL_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_ref_bit,
  input  logic                   in_rx_bit,
  input  logic                   in_frame_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [TOTAL_WIDTH-1:0] out_error_total,
  output logic [TOTAL_WIDTH-1:0] out_correct_total,
  output logic [FRAME_W-1:0]     out_frame_error_count
);

  localparam int DW  = $clog2(MAX_DELAY + 1);
  localparam int AW  = (DW > ALIGN_W) ? DW : ALIGN_W;
  localparam int IW  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int LW  = DW + 1;
  localparam int KW  = $clog2(MAX_SKIP_LAST + 1);
  localparam int SW  = (KW > SKIP_LAST_W) ? KW : SKIP_LAST_W;
  localparam int PIW = (MAX_SKIP_LAST > 1) ? $clog2(MAX_SKIP_LAST) : 1;
  localparam int QW  = KW + 1;
  localparam int PW  = FRAME_W + 1;

  function automatic logic [DW-1:0] delay_mag(input logic [ALIGN_W-1:0] a);
    logic [ALIGN_W-1:0] a_abs;
    logic [AW-1:0]      a_ext;
    a_abs = a[ALIGN_W-1] ? (~a + {{(ALIGN_W-1){1'b0}}, 1'b1}) : a;
    a_ext = AW'(a_abs);
    return (a_ext > AW'(MAX_DELAY)) ? DW'(MAX_DELAY) : DW'(a_ext);
  endfunction

  logic [ALIGN_W-1:0]      align_r;
  logic [SKIP_FIRST_W-1:0] skip_first_r;
  logic [SKIP_LAST_W-1:0]  skip_last_r;

  logic                     line_mem [MAX_DELAY];
  logic                     pend_mem [MAX_SKIP_LAST];
  logic                     line_q_r, pend_q_r;
  logic [IW-1:0]            wp_r, wp_nxt;
  logic [DW-1:0]            line_cnt_r, line_cnt_nxt;
  logic [PIW-1:0]           head_r, head_nxt;
  logic [KW-1:0]            fill_r, fill_nxt;
  logic [FRAME_W-1:0]       frame_pos_r, frame_pos_nxt;
  logic [FRAME_W-1:0]       frame_err_r, frame_err_nxt;
  logic [TOTAL_WIDTH-1:0]   errors_r, errors_nxt;
  logic [TOTAL_WIDTH-1:0]   corrects_r, corrects_nxt;
  logic [FRAME_W-1:0]       out_frame_err_r;
  logic                     out_valid_r;

  logic               in_fire;
  logic               delay_neg;
  logic [ALIGN_W-1:0] align_nxt;
  logic [DW-1:0]      mag, mag_nxt;
  logic [IW-1:0]      wp_inc, line_ra;
  logic [LW-1:0]      line_sum;
  logic [PIW-1:0]     head_inc, pend_wa;
  logic [QW-1:0]      pend_sum;
  logic               delayed_now, other_bit, delayed_old, mismatch;
  logic [SW-1:0]      skip_last_ext;
  logic [KW-1:0]      keep;
  logic               compare_en;
  logic               push, pop;
  logic               commit_valid, commit_bit;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  assign out_error_total       = errors_r;
  assign out_correct_total     = corrects_r;
  assign out_frame_error_count = out_frame_err_r;

  // alignment: the delayed stream is ref for a non-negative delay, rx otherwise
  assign delay_neg   = align_r[ALIGN_W-1];
  assign mag         = delay_mag(align_r);
  assign delayed_now = delay_neg ? in_rx_bit : in_ref_bit;
  assign other_bit   = delay_neg ? in_ref_bit : in_rx_bit;
  // entries older than the write count were never written and read as zero
  assign delayed_old = (mag == '0) ? delayed_now :
                       (line_cnt_r < mag) ? 1'b0 : line_q_r;
  assign mismatch    = delayed_old ^ other_bit;

  // delay line read is registered ahead, addressed by the next beat's pointer and delay
  assign align_nxt = (cfg_we && cfg_reg_t'(cfg_index) == REG_ALIGN_DELAY) ?
                     cfg_data[ALIGN_W-1:0] : align_r;
  assign mag_nxt   = delay_mag(align_nxt);
  assign wp_inc    = (wp_r == IW'(MAX_DELAY - 1)) ? '0 : wp_r + IW'(1);
  assign wp_nxt    = in_fire ? wp_inc : wp_r;
  assign line_sum  = LW'(wp_nxt) + LW'(MAX_DELAY) - LW'(mag_nxt);
  assign line_ra   = (line_sum >= LW'(MAX_DELAY)) ? IW'(line_sum - LW'(MAX_DELAY))
                                                  : IW'(line_sum);
  assign line_cnt_nxt = (in_fire && line_cnt_r != DW'(MAX_DELAY)) ?
                        line_cnt_r + DW'(1) : line_cnt_r;

  assign skip_last_ext = SW'(skip_last_r);
  assign keep = (skip_last_ext > SW'(MAX_SKIP_LAST)) ? KW'(MAX_SKIP_LAST) : KW'(skip_last_ext);

  assign compare_en = PW'(frame_pos_r) >= (PW'(skip_first_r) + PW'(mag));

  // pending queue is a ring: oldest at head, new entries go to head + fill
  assign head_inc = (head_r == PIW'(MAX_SKIP_LAST - 1)) ? '0 : head_r + PIW'(1);
  assign pend_sum = QW'(head_r) + QW'(fill_r);
  assign pend_wa  = (pend_sum >= QW'(MAX_SKIP_LAST)) ? PIW'(pend_sum - QW'(MAX_SKIP_LAST))
                                                     : PIW'(pend_sum);
  assign head_nxt = !in_fire ? head_r : (in_frame_end ? '0 : (pop ? head_inc : head_r));

  always_comb begin
    commit_valid = 1'b0;
    commit_bit   = mismatch;
    push         = 1'b0;
    pop          = 1'b0;
    fill_nxt     = fill_r;
    if (compare_en) begin
      if (keep == '0 && fill_r == '0) begin
        commit_valid = 1'b1;
      end else if (fill_r >= keep) begin
        // queue full for this keep: oldest leaves, new one enters
        commit_valid = 1'b1;
        commit_bit   = pend_q_r;
        push         = 1'b1;
        pop          = 1'b1;
      end else begin
        push     = 1'b1;
        fill_nxt = fill_r + KW'(1);
      end
    end

    errors_nxt    = errors_r;
    corrects_nxt  = corrects_r;
    frame_err_nxt = frame_err_r;
    if (commit_valid) begin
      if (commit_bit) begin
        if (!(&errors_r)) errors_nxt = errors_r + TOTAL_WIDTH'(1);
        if (!(&frame_err_r)) frame_err_nxt = frame_err_r + FRAME_W'(1);
      end else begin
        if (!(&corrects_r)) corrects_nxt = corrects_r + TOTAL_WIDTH'(1);
      end
    end

    frame_pos_nxt = (&frame_pos_r) ? frame_pos_r : frame_pos_r + FRAME_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r      <= '0;
      skip_first_r <= '0;
      skip_last_r  <= '0;
      wp_r         <= '0;
      line_cnt_r   <= '0;
      head_r       <= '0;
      fill_r       <= '0;
      frame_pos_r  <= '0;
      frame_err_r  <= '0;
      errors_r     <= '0;
      corrects_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ALIGN_DELAY: align_r      <= cfg_data[ALIGN_W-1:0];
          REG_SKIP_FIRST:  skip_first_r <= cfg_data[SKIP_FIRST_W-1:0];
          REG_SKIP_LAST:   skip_last_r  <= cfg_data[SKIP_LAST_W-1:0];
          default: ;
        endcase
      end
      wp_r       <= wp_nxt;
      line_cnt_r <= line_cnt_nxt;
      head_r     <= head_nxt;
      if (in_fire) begin
        errors_r   <= errors_nxt;
        corrects_r <= corrects_nxt;
        if (in_frame_end) begin
          fill_r      <= '0;
          frame_pos_r <= '0;
          frame_err_r <= '0;
        end else begin
          fill_r      <= fill_nxt;
          frame_pos_r <= frame_pos_nxt;
          frame_err_r <= frame_err_nxt;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // registered reads bypass the write of the same edge
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_frame_err_r <= frame_err_nxt;
      line_mem[wp_r]  <= delayed_now;
      if (push) pend_mem[pend_wa] <= mismatch;
    end
    line_q_r <= (in_fire && line_ra == wp_r) ? delayed_now : line_mem[line_ra];
    pend_q_r <= (in_fire && push && pend_wa == head_nxt) ? mismatch : pend_mem[head_nxt];
  end

  `BERC_ASSERT(a_fill_bound, (fill_r <= KW'(MAX_SKIP_LAST)), "pending fill beyond queue depth")
  `BERC_ASSERT_NEXT(a_idle_hold, !in_fire,
    $stable(errors_r) && $stable(corrects_r) && $stable(fill_r) && $stable(frame_pos_r),
    "counter state moved without an input beat")
  `BERC_ASSERT_NEXT(a_frame_clear, in_fire && in_frame_end,
    fill_r == '0 && frame_pos_r == '0 && frame_err_r == '0,
    "frame state not cleared after frame end")

endmodule
